// ===== src/rspd_pkg.sv =====
`timescale 1ns / 1ps

package rspd_pkg;

  localparam int BYTE_W           = 8;
  localparam int PKT_LEN          = 7;
  localparam int SUM_LEN          = PKT_LEN - 1;
  localparam int SUM_W            = BYTE_W + $clog2(SUM_LEN + 1);
  localparam int FILL_W           = $clog2(PKT_LEN);
  localparam int SWEEP_BIT        = 0;
  localparam int SAMPLE_COUNT_MAX = 1023;
  localparam int IDX_W            = 10;
  localparam int CNT_RAW_W        = $clog2(SAMPLE_COUNT_MAX + 1);
  localparam int CNT_W            = (CNT_RAW_W > IDX_W) ? CNT_RAW_W : IDX_W;
  localparam int FAIL_W           = 8;
  localparam int WORD_W           = 2 * BYTE_W;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SUM_LEN);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(SAMPLE_COUNT_MAX);
  localparam logic [FAIL_W-1:0] FAIL_MAX  = {FAIL_W{1'b1}};
  localparam logic [BYTE_W:0]   SUM_MOD   = (BYTE_W + 1)'(255);

  typedef struct packed {
    logic pass;
    logic fail;
    logic start;
  } chk_evt_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  prev_total;
    logic [FAIL_W-1:0] fails;
  } sweep_info_t;

  // end-around fold: 256 is 1 modulo 255
  function automatic logic [BYTE_W-1:0] mod255(input logic [SUM_W-1:0] s);
    logic [BYTE_W:0] t;
    t = (BYTE_W + 1)'(s[SUM_W-1:BYTE_W]) + (BYTE_W + 1)'(s[BYTE_W-1:0]);
    if (t >= SUM_MOD) begin
      t = t - SUM_MOD;
    end
    return t[BYTE_W-1:0];
  endfunction

endpackage

// ===== src/rspd_in_if.sv =====
`timescale 1ns / 1ps

interface rspd_in_if import rspd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/rspd_out_if.sv =====
`timescale 1ns / 1ps

interface rspd_out_if import rspd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              sweep_start;
  logic [WORD_W-1:0] angle_q4;
  logic [WORD_W-1:0] range_value;
  logic [IDX_W-1:0]  sample_index;
  logic [IDX_W-1:0]  previous_sweep_total;
  logic [FAIL_W-1:0] bad_checksums;

  modport source (output valid, output sweep_start, output angle_q4, output range_value,
                  output sample_index, output previous_sweep_total, output bad_checksums,
                  input ready);
  modport sink   (input valid, input sweep_start, input angle_q4, input range_value,
                  input sample_index, input previous_sweep_total, input bad_checksums,
                  output ready);
endinterface

// ===== src/rspd_cell.sv =====
`timescale 1ns / 1ps

module rspd_cell import rspd_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [BYTE_W-1:0] byte_out,
  input  logic [SUM_W-1:0]  sum_in,
  output logic [SUM_W-1:0]  sum_out
);

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign sum_out  = sum_in + SUM_W'(byte_r);

endmodule

// ===== src/rspd_sweep.sv =====
`timescale 1ns / 1ps

module rspd_sweep import rspd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chk_evt_t    evt,
  output sweep_info_t info
);

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_base;
  logic [FAIL_W-1:0] fail_r;
  logic [FAIL_W-1:0] fail_nxt;

  assign cnt_base = evt.start ? '0 : cnt_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    if (evt.pass) begin
      cnt_nxt  = (cnt_base < CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
      fail_nxt = '0;
    end else if (evt.fail && fail_r != FAIL_MAX) begin
      fail_nxt = fail_r + FAIL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fail_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      fail_r <= fail_nxt;
    end
  end

  assign info.index      = cnt_base[IDX_W-1:0];
  assign info.prev_total = evt.start ? cnt_r[IDX_W-1:0] : '0;
  assign info.fails      = fail_r;

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    evt.pass && evt.start |=> cnt_r == CNT_W'(1))
    else $error("sweep start did not restart the sample count");

  a_fail_counts: assert property (@(posedge clk) disable iff (!rst_n)
    evt.fail && !evt.pass && fail_r != FAIL_MAX |=> fail_r == $past(fail_r) + FAIL_W'(1))
    else $error("checksum failure not counted");

  a_pass_clears: assert property (@(posedge clk) disable iff (!rst_n)
    evt.pass |=> fail_r == '0)
    else $error("failure count not cleared by emitted sample");

endmodule

// ===== src/range_sample_packet_deframer.sv =====
`timescale 1ns / 1ps

// Packet deframer for a range sensor byte stream. One byte is taken per clock; bytes shift
// through a row of six cells that also carry a running sum, so when six bytes are held the
// next byte is compared with their sum modulo 255 in the same cycle. A match gives one
// sample word on the output the cycle after the seventh byte and empties the window; a
// mismatch drops the oldest byte and counts a failure. The input takes one byte per cycle
// while no sample is held back on the output; while one is held back, a byte is still accepted
// unless six bytes are held, and then it waits for the output to drain, whether it matches or not.

module range_sample_packet_deframer import rspd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rspd_in_if.sink   in_ch,
  rspd_out_if.source out_ch
);

  logic [BYTE_W-1:0] cell_byte [SUM_LEN];
  logic [SUM_W-1:0]  cell_sum  [SUM_LEN+1];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              out_valid_r;
  logic              in_acc;
  logic              full;
  logic              match;
  logic              load;
  chk_evt_t          evt;
  sweep_info_t       info;

  logic              start_r;
  logic [WORD_W-1:0] angle_r;
  logic [WORD_W-1:0] range_r;
  logic [IDX_W-1:0]  index_r;
  logic [IDX_W-1:0]  prev_r;
  logic [FAIL_W-1:0] fails_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready || (fill_r != FILL_FULL);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cell_sum[0] = '0;

  // cell 0 holds the oldest byte, new bytes enter at the top cell
  for (genvar i = 0; i < SUM_LEN; i++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (i == SUM_LEN - 1) begin : g_top
      assign feed = in_ch.rx_byte;
    end else begin : g_mid
      assign feed = cell_byte[i+1];
    end
    rspd_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (feed),
      .byte_out (cell_byte[i]),
      .sum_in   (cell_sum[i]),
      .sum_out  (cell_sum[i+1])
    );
  end

  assign full  = (fill_r == FILL_FULL);
  assign match = (mod255(cell_sum[SUM_LEN]) == in_ch.rx_byte);
  assign load  = in_acc && full && match;

  assign evt.pass  = load;
  assign evt.fail  = in_acc && full && !match;
  assign evt.start = cell_byte[0][SWEEP_BIT];

  rspd_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .info  (info)
  );

  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      if (!full) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else if (match) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= evt.start;
      angle_r <= {cell_byte[2], cell_byte[1]};
      range_r <= {cell_byte[4], cell_byte[3]};
      index_r <= info.index;
      prev_r  <= info.prev_total;
      fails_r <= info.fails;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.sweep_start          = start_r;
  assign out_ch.angle_q4             = angle_r;
  assign out_ch.range_value          = range_r;
  assign out_ch.sample_index         = index_r;
  assign out_ch.previous_sweep_total = prev_r;
  assign out_ch.bad_checksums        = fails_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill out of range");

  a_load_empties: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && fill_r == '0)
    else $error("emitted sample did not empty the window");

  a_mismatch_keeps_six: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && full && !match |=> fill_r == FILL_FULL)
    else $error("mismatch did not keep six bytes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && in_acc |-> !full)
    else $error("completing byte taken while a sample is pending");

endmodule

// ===== test/range_sample_packet_deframer_test.sv =====
`timescale 1ns / 1ps

module range_sample_packet_deframer_test;
  import rspd_pkg::*;

  localparam int CHECK_MOD      = 255;
  localparam int IDLE_PCT       = 26;
  localparam int STALL_LIMIT    = 5000;
  localparam int ITEM_COUNT     = 750;
  localparam int SWEEP_PACKETS  = 40;
  localparam int STEADY_PACKETS = 30;

  typedef struct {
    logic [BYTE_W-1:0] value;
    bit                drain_first;
    bit                steady;
  } byte_item_t;

  typedef struct packed {
    logic              sweep_start;
    logic [WORD_W-1:0] angle_q4;
    logic [WORD_W-1:0] range_value;
    logic [IDX_W-1:0]  sample_index;
    logic [IDX_W-1:0]  previous_sweep_total;
    logic [FAIL_W-1:0] bad_checksums;
  } sample_t;

  logic clk;
  logic rst_n;

  rspd_in_if  in_ch ();
  rspd_out_if out_ch ();

  range_sample_packet_deframer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  byte_item_t pending_bytes[$];
  sample_t    expected_samples[$];

  logic [BYTE_W-1:0] frame_win[PKT_LEN];
  int unsigned       frame_fill;
  logic [CNT_W-1:0]  sweep_count;
  logic [FAIL_W-1:0] fail_count;

  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          steady_mode;
  sample_t     seen_sample;
  sample_t     due_sample;

  always #10 clk = ~clk;

  // sliding seven-byte window with checksum over the first six
  task automatic frame_byte(input logic [BYTE_W-1:0] b);
    int unsigned total;
    sample_t s;
    if (frame_fill >= PKT_LEN) frame_fill = 0;
    frame_win[frame_fill] = b;
    frame_fill++;
    if (frame_fill < PKT_LEN) return;
    total = 0;
    for (int i = 0; i < SUM_LEN; i++) total += frame_win[i];
    if (total % CHECK_MOD != frame_win[PKT_LEN-1]) begin
      for (int i = 0; i < PKT_LEN - 1; i++) frame_win[i] = frame_win[i+1];
      frame_win[PKT_LEN-1] = '0;
      frame_fill = PKT_LEN - 1;
      if (fail_count != FAIL_MAX) fail_count++;
      return;
    end
    s.sweep_start = frame_win[0][SWEEP_BIT];
    s.previous_sweep_total = '0;
    if (s.sweep_start) begin
      s.previous_sweep_total = sweep_count[IDX_W-1:0];
      sweep_count = '0;
    end
    s.angle_q4 = {frame_win[2], frame_win[1]};
    s.range_value = {frame_win[4], frame_win[3]};
    s.sample_index = sweep_count[IDX_W-1:0];
    if (sweep_count < CNT_MAX) sweep_count++;
    s.bad_checksums = fail_count;
    fail_count = '0;
    for (int i = 0; i < PKT_LEN; i++) frame_win[i] = '0;
    frame_fill = 0;
    expected_samples.push_back(s);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] value, input bit drain_first,
                            input bit steady);
    byte_item_t item;
    item.value = value;
    item.drain_first = drain_first;
    item.steady = steady;
    pending_bytes.push_back(item);
  endtask

  // flip nonzero corrupts the checksum, count below seven truncates the packet
  task automatic queue_packet(input logic [BYTE_W-1:0] status, input logic [WORD_W-1:0] angle,
                              input logic [WORD_W-1:0] range_word,
                              input logic [BYTE_W-1:0] spare, input logic [BYTE_W-1:0] flip,
                              input int count, input bit drain_first, input bit steady);
    logic [BYTE_W-1:0] pkt[PKT_LEN];
    int unsigned total;
    pkt[0] = status;
    pkt[1] = angle[BYTE_W-1:0];
    pkt[2] = angle[WORD_W-1:BYTE_W];
    pkt[3] = range_word[BYTE_W-1:0];
    pkt[4] = range_word[WORD_W-1:BYTE_W];
    pkt[5] = spare;
    total = 0;
    for (int i = 0; i < SUM_LEN; i++) total += pkt[i];
    pkt[6] = BYTE_W'(total % CHECK_MOD) ^ flip;
    for (int i = 0; i < count; i++) queue_byte(pkt[i], drain_first && i == 0, steady);
  endtask

  function automatic void note_mismatch(input string what, input sample_t exp_s,
                                        input sample_t got_s);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%s: expected start=%0d angle=%h range=%h index=%0d prev=%0d fails=%0d, ",
             what, exp_s.sweep_start, exp_s.angle_q4, exp_s.range_value,
             exp_s.sample_index, exp_s.previous_sweep_total, exp_s.bad_checksums);
      $display("got start=%0d angle=%h range=%h index=%0d prev=%0d fails=%0d",
               got_s.sweep_start, got_s.angle_q4, got_s.range_value,
               got_s.sample_index, got_s.previous_sweep_total, got_s.bad_checksums);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) frame_byte(in_ch.rx_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].drain_first && expected_samples.size() != 0) &&
            (pending_bytes[0].steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= pending_bytes[0].value;
          steady_mode <= pending_bytes[0].steady;
          void'(pending_bytes.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
          in_ch.rx_byte <= BYTE_W'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_sample.sweep_start = out_ch.sweep_start;
        seen_sample.angle_q4 = out_ch.angle_q4;
        seen_sample.range_value = out_ch.range_value;
        seen_sample.sample_index = out_ch.sample_index;
        seen_sample.previous_sweep_total = out_ch.previous_sweep_total;
        seen_sample.bad_checksums = out_ch.bad_checksums;
        if (expected_samples.size() == 0) begin
          note_mismatch("unexpected sample", '0, seen_sample);
        end else begin
          due_sample = expected_samples.pop_front();
          if (seen_sample !== due_sample) note_mismatch("sample mismatch", due_sample, seen_sample);
        end
      end
      out_ch.ready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    logic [BYTE_W-1:0] status;
    logic [WORD_W-1:0] angle;
    logic [WORD_W-1:0] range_word;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    steady_mode = 1'b0;
    for (int i = 0; i < PKT_LEN; i++) frame_win[i] = '0;
    frame_fill = 0;
    sweep_count = '0;
    fail_count = '0;
    mismatches = 0;
    stall_cycles = 0;

    // directed: sweep start with extreme angle, extreme range, all-zero packet
    queue_packet(8'h01, 16'hFFFF, 16'h0000, 8'h00, 8'h00, PKT_LEN, 0, 0);
    queue_packet(8'hFE, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, PKT_LEN, 0, 0);
    queue_packet(8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, PKT_LEN, 0, 0);
    // checksum byte of 255 never matches
    queue_byte(8'h81, 0, 0);
    queue_byte(8'h7F, 0, 0);
    for (int i = 0; i < 4; i++) queue_byte(8'h00, 0, 0);
    queue_byte(8'hFF, 0, 0);
    queue_byte(8'h5A, 0, 0);
    queue_byte(8'hA5, 0, 0);
    queue_byte(8'h3C, 0, 0);

    // long run of failures to saturate the failure count, then resync on a start
    for (int i = 0; i < 300; i++) queue_byte(8'hFF, i == 0, 0);
    queue_packet(8'h01, 16'h1234, 16'h0567, 8'h00, 8'h00, PKT_LEN, 0, 0);

    // long sweep, first part with no idling
    for (int i = 0; i < SWEEP_PACKETS; i++)
      queue_packet(BYTE_W'($urandom) & 8'hFE, WORD_W'($urandom), WORD_W'($urandom),
                   BYTE_W'($urandom), 8'h00, PKT_LEN, i == 0, i < STEADY_PACKETS);
    queue_packet(8'h01, 16'h0F00, 16'h00F0, 8'h11, 8'h00, PKT_LEN, 0, 0);

    // random traffic: mostly good packets, some corrupt, noise and truncated
    while (pending_bytes.size() < ITEM_COUNT) begin
      kind = $urandom_range(99);
      status = BYTE_W'($urandom);
      status[SWEEP_BIT] = ($urandom_range(7) == 0);
      angle = ($urandom_range(9) == 0) ? 16'hFFFF : WORD_W'($urandom);
      range_word = ($urandom_range(9) == 0) ? 16'h0000 : WORD_W'($urandom);
      if (kind < 70)
        queue_packet(status, angle, range_word, BYTE_W'($urandom), 8'h00, PKT_LEN, 0, 0);
      else if (kind < 80)
        queue_packet(status, angle, range_word, BYTE_W'($urandom),
                     BYTE_W'($urandom_range(1, 255)), PKT_LEN, 0, 0);
      else if (kind < 90)
        for (int i = $urandom_range(1, 6); i > 0; i--) queue_byte(BYTE_W'($urandom), 0, 0);
      else
        queue_packet(status, angle, range_word, BYTE_W'($urandom), 8'h00,
                     $urandom_range(1, PKT_LEN - 1), 0, 0);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_samples.size() != 0)
      $display("%0d expected samples never arrived", expected_samples.size());
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
